FILE: rtl/itfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itfp_pkg;

  localparam int SigSymbols = 104;
  localparam int QDepth     = 4;
  localparam int QAw        = $clog2(QDepth);

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SYMBOL = 1'b1;

  localparam logic [2:0] KIND_TIMESTAMP = 3'd0;
  localparam logic [2:0] KIND_HEADER    = 3'd1;
  localparam logic [2:0] KIND_BYTE      = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_SIG       = 3'd4;
  localparam logic [2:0] KIND_ERROR     = 3'd5;
  localparam logic [2:0] KIND_DONE      = 3'd6;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  symbol;
    logic [11:0] symbol_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  tag;
    logic [9:0]  field_length;
    logic        accepted;
    logic [7:0]  byte_value;
    logic [3:0]  hop_index;
    logic [5:0]  hop_offset;
    logic [34:0] timestamp_value;
    logic [9:0]  cltv_value;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

  // One input beat's worth of results: one or two.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/itfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itfp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire itfp_pkg::in_t   item,
  output logic                 step_valid,
  output itfp_pkg::step_t      step
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TIME = 3'd1;
  localparam logic [2:0] PH_TAG  = 3'd2;
  localparam logic [2:0] PH_LHI  = 3'd3;
  localparam logic [2:0] PH_LLO  = 3'd4;
  localparam logic [2:0] PH_VAL  = 3'd5;
  localparam logic [2:0] PH_SKIP = 3'd6;
  localparam logic [2:0] PH_SIG  = 3'd7;

  localparam logic [4:0] TAG_HASH    = 5'd1;
  localparam logic [4:0] TAG_ROUTE   = 5'd3;
  localparam logic [4:0] TAG_FEAT    = 5'd5;
  localparam logic [4:0] TAG_EXPIRY  = 5'd6;
  localparam logic [4:0] TAG_DESC    = 5'd13;
  localparam logic [4:0] TAG_SECRET  = 5'd16;
  localparam logic [4:0] TAG_NODE    = 5'd19;
  localparam logic [4:0] TAG_CLTV    = 5'd24;

  localparam logic [9:0] LEN_HASH = 10'd52;
  localparam logic [9:0] LEN_NODE = 10'd53;
  localparam logic [5:0] HOP_LAST = 6'd50;

  logic [2:0]  phase, phase_next;
  logic [11:0] pos, pos_next;
  logic [11:0] data_symbols, data_symbols_next;
  logic [34:0] time_shift, time_shift_next;
  logic [4:0]  cur_tag, cur_tag_next;
  logic [9:0]  length_reg, length_reg_next;
  logic [9:0]  value_left, value_left_next;
  logic [11:0] bit_acc, bit_acc_next;
  logic [3:0]  bit_fill, bit_fill_next;
  logic [3:0]  hop_index, hop_index_next;
  logic [5:0]  hop_offset, hop_offset_next;
  logic        text_ended, text_ended_next;

  logic [1:0]  n_res;

  function automatic logic tag_known(input logic [4:0] t);
    logic k;
    unique case (t) inside
      TAG_HASH, TAG_ROUTE, TAG_FEAT, TAG_EXPIRY,
      TAG_DESC, TAG_SECRET, TAG_NODE, TAG_CLTV: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic tag_ok(input logic [4:0] t, input logic [9:0] n);
    logic k;
    unique case (t) inside
      TAG_HASH, TAG_SECRET:                    k = (n == LEN_HASH);
      TAG_NODE:                                k = (n == LEN_NODE);
      TAG_CLTV:                                k = (n == 10'd1) || (n == 10'd2);
      TAG_ROUTE, TAG_FEAT, TAG_EXPIRY, TAG_DESC: k = 1'b1;
      default:                                 k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic itfp_pkg::res_t mk(
    input logic [2:0]  kind,
    input logic        fld,
    input logic [4:0]  tg,
    input logic [9:0]  ln,
    input logic [7:0]  bv,
    input logic [3:0]  hi,
    input logic [5:0]  ho,
    input logic [34:0] ts,
    input logic [9:0]  cl,
    input logic [1:0]  ec
  );
    itfp_pkg::res_t r;
    r                 = '0;
    r.kind            = kind;
    r.tag             = fld ? tg : 5'd0;
    r.field_length    = fld ? ln : 10'd0;
    r.accepted        = fld && tag_ok(tg, ln);
    r.byte_value      = bv;
    r.hop_index       = hi;
    r.hop_offset      = ho;
    r.timestamp_value = ts;
    r.cltv_value      = cl;
    r.error_code      = ec;
    return r;
  endfunction

  // Effective view of the step after the switch into the signature section.
  logic [2:0]  ph;
  logic [11:0] eacc;
  logic [3:0]  efill;
  logic [11:0] rg_acc;
  logic [3:0]  rg_fill5;
  logic        rg_hit;
  logic [3:0]  rg_fill;
  logic [7:0]  rg_byte;
  logic [11:0] ds_new;
  logic [9:0]  len_full;
  logic        acc_now;
  logic [9:0]  cltv_acc;
  logic [9:0]  left_dec;
  logic [12:0] pos_p1;
  logic        emit_byte;
  itfp_pkg::res_t r0, r1;

  assign pos_p1   = {1'b0, pos} + 13'd1;
  assign len_full = {length_reg[9:5], item.symbol};
  assign acc_now  = tag_ok(cur_tag, length_reg);
  assign cltv_acc = {bit_acc[4:0], item.symbol};
  assign left_dec = value_left - 10'd1;
  assign ds_new   = item.symbol_count - 12'(itfp_pkg::SigSymbols);

  always_comb begin
    ph    = phase;
    eacc  = bit_acc;
    efill = bit_fill;
    if (phase != PH_IDLE && phase != PH_SIG && pos >= data_symbols) begin
      ph    = PH_SIG;
      eacc  = '0;
      efill = '0;
    end
    rg_acc   = {eacc[6:0], item.symbol};
    rg_fill5 = efill + 4'd5;
    rg_hit   = rg_fill5 >= 4'd8;
    rg_fill  = rg_hit ? rg_fill5 - 4'd8 : rg_fill5;
    rg_byte  = 8'(rg_acc >> rg_fill);
  end

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    data_symbols_next = data_symbols;
    time_shift_next   = time_shift;
    cur_tag_next      = cur_tag;
    length_reg_next   = length_reg;
    value_left_next   = value_left;
    bit_acc_next      = bit_acc;
    bit_fill_next     = bit_fill;
    hop_index_next    = hop_index;
    hop_offset_next   = hop_offset;
    text_ended_next   = text_ended;
    n_res             = 2'd0;
    r0                = '0;
    r1                = '0;
    emit_byte         = 1'b0;

    if (item.cmd == itfp_pkg::CMD_START) begin
      phase_next        = PH_IDLE;
      pos_next          = '0;
      data_symbols_next = '0;
      time_shift_next   = '0;
      cur_tag_next      = '0;
      length_reg_next   = '0;
      value_left_next   = '0;
      bit_acc_next      = '0;
      bit_fill_next     = '0;
      hop_index_next    = '0;
      hop_offset_next   = '0;
      text_ended_next   = 1'b0;
      n_res             = 2'd1;
      if (item.symbol_count <= 12'(itfp_pkg::SigSymbols)) begin
        r0 = mk(itfp_pkg::KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, '0, '0,
                itfp_pkg::ERR_SHORT);
      end else begin
        data_symbols_next = ds_new;
        if (ds_new < 12'd7) begin
          phase_next = PH_SKIP;
          r0 = mk(itfp_pkg::KIND_ERROR, 1'b1, '0, '0, '0, '0, '0, '0, '0,
                  itfp_pkg::ERR_TRUNC);
        end else begin
          phase_next = PH_TIME;
          n_res      = 2'd0;
        end
      end
    end else if (phase != PH_IDLE) begin
      pos_next      = pos_p1[11:0];
      bit_acc_next  = eacc;
      bit_fill_next = efill;
      phase_next    = ph;
      unique case (ph)
        PH_TIME: begin
          time_shift_next = {time_shift[29:0], item.symbol};
          if (pos == 12'd6) begin
            n_res      = 2'd1;
            r0 = mk(itfp_pkg::KIND_TIMESTAMP, 1'b0, '0, '0, '0, '0, '0,
                    {time_shift[29:0], item.symbol}, '0, itfp_pkg::ERR_NONE);
            phase_next = PH_TAG;
          end
        end
        PH_TAG: begin
          cur_tag_next    = item.symbol;
          length_reg_next = '0;
          if ({1'b0, pos} + 13'd3 > {1'b0, data_symbols}) begin
            n_res      = 2'd1;
            r0 = mk(itfp_pkg::KIND_ERROR, 1'b1, item.symbol, '0, '0, '0, '0,
                    '0, '0, itfp_pkg::ERR_TRUNC);
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_LHI;
          end
        end
        PH_LHI: begin
          length_reg_next = {item.symbol, 5'd0};
          phase_next      = PH_LLO;
        end
        PH_LLO: begin
          length_reg_next = len_full;
          n_res           = 2'd1;
          if (pos_p1 + {3'd0, len_full} > {1'b0, data_symbols}) begin
            r0 = mk(itfp_pkg::KIND_ERROR, 1'b1, cur_tag, len_full, '0, '0, '0,
                    '0, '0, itfp_pkg::ERR_TRUNC);
            phase_next = PH_SKIP;
          end else begin
            bit_acc_next    = '0;
            bit_fill_next   = '0;
            hop_index_next  = '0;
            hop_offset_next = '0;
            text_ended_next = 1'b0;
            r0 = mk(itfp_pkg::KIND_HEADER, 1'b1, cur_tag, len_full, '0, '0, '0,
                    '0, '0, itfp_pkg::ERR_NONE);
            if (len_full == 10'd0) begin
              n_res      = 2'd2;
              r1 = mk(itfp_pkg::KIND_END, 1'b1, cur_tag, len_full, '0, '0, '0,
                      '0, '0, itfp_pkg::ERR_NONE);
              phase_next = PH_TAG;
            end else begin
              value_left_next = len_full;
              phase_next      = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          if (cur_tag == TAG_CLTV) begin
            if (acc_now) bit_acc_next = {2'd0, cltv_acc};
          end else if (tag_known(cur_tag)) begin
            bit_acc_next  = rg_acc;
            bit_fill_next = rg_fill;
            if (rg_hit) begin
              emit_byte = 1'b1;
              if (cur_tag == TAG_DESC) begin
                // drop everything from the first zero byte on
                if (text_ended || rg_byte == 8'd0) begin
                  text_ended_next = 1'b1;
                  emit_byte       = 1'b0;
                end
              end else if (cur_tag == TAG_ROUTE) begin
                if (hop_offset == HOP_LAST) begin
                  hop_offset_next = '0;
                  hop_index_next  = hop_index + 4'd1;
                end else begin
                  hop_offset_next = hop_offset + 6'd1;
                end
              end
            end
          end
          if (emit_byte) begin
            n_res = 2'd1;
            r0 = mk(itfp_pkg::KIND_BYTE, 1'b1, cur_tag, length_reg, rg_byte,
                    (cur_tag == TAG_ROUTE) ? hop_index : 4'd0,
                    (cur_tag == TAG_ROUTE) ? hop_offset : 6'd0,
                    '0, '0, itfp_pkg::ERR_NONE);
          end
          value_left_next = left_dec;
          if (left_dec == 10'd0) begin
            if (emit_byte) begin
              n_res = 2'd2;
              r1 = mk(itfp_pkg::KIND_END, 1'b1, cur_tag, length_reg, '0, '0, '0,
                      '0, (cur_tag == TAG_CLTV && acc_now) ? cltv_acc : 10'd0,
                      itfp_pkg::ERR_NONE);
            end else begin
              n_res = 2'd1;
              r0 = mk(itfp_pkg::KIND_END, 1'b1, cur_tag, length_reg, '0, '0, '0,
                      '0, (cur_tag == TAG_CLTV && acc_now) ? cltv_acc : 10'd0,
                      itfp_pkg::ERR_NONE);
            end
            phase_next = PH_TAG;
          end
        end
        PH_SIG: begin
          bit_acc_next  = rg_acc;
          bit_fill_next = rg_fill;
          if (rg_hit) begin
            n_res = 2'd1;
            r0 = mk(itfp_pkg::KIND_SIG, 1'b0, '0, '0, rg_byte, '0, '0, '0, '0,
                    itfp_pkg::ERR_NONE);
          end
          if (pos_p1 >= {1'b0, data_symbols} + 13'(itfp_pkg::SigSymbols)) begin
            if (rg_hit) begin
              n_res = 2'd2;
              r1 = mk(itfp_pkg::KIND_DONE, 1'b0, '0, '0, '0, '0, '0, '0, '0,
                      itfp_pkg::ERR_NONE);
            end else begin
              n_res = 2'd1;
              r0 = mk(itfp_pkg::KIND_DONE, 1'b0, '0, '0, '0, '0, '0, '0, '0,
                      itfp_pkg::ERR_NONE);
            end
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // skipping: only the position advances
        end
      endcase
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  assign step_valid = accept && (n_res != 2'd0);
  assign step.two   = (n_res == 2'd2);
  assign step.r0    = r0;
  assign step.r1    = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pos          <= '0;
      data_symbols <= '0;
      time_shift   <= '0;
      cur_tag      <= '0;
      length_reg   <= '0;
      value_left   <= '0;
      bit_acc      <= '0;
      bit_fill     <= '0;
      hop_index    <= '0;
      hop_offset   <= '0;
      text_ended   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      pos          <= pos_next;
      data_symbols <= data_symbols_next;
      time_shift   <= time_shift_next;
      cur_tag      <= cur_tag_next;
      length_reg   <= length_reg_next;
      value_left   <= value_left_next;
      bit_acc      <= bit_acc_next;
      bit_fill     <= bit_fill_next;
      hop_index    <= hop_index_next;
      hop_offset   <= hop_offset_next;
      text_ended   <= text_ended_next;
    end
  end

  a_active_has_data: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> data_symbols != 12'd0)
    else $error("parser active with no data symbols");

  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    step_valid && step.two |->
      step.r1.kind == itfp_pkg::KIND_END || step.r1.kind == itfp_pkg::KIND_DONE)
    else $error("second result of a beat is not a field end or done");

  a_hop_range: assert property (@(posedge clk) disable iff (rst)
    hop_offset <= HOP_LAST && bit_fill <= 4'd7)
    else $error("hop offset or fill count out of range");

endmodule

`default_nettype wire

FILE: rtl/itfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itfp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire itfp_pkg::step_t  wr_data,
  input  wire logic             rd,
  output itfp_pkg::step_t       head,
  output logic                  is_empty,
  output logic                  is_full
);

  itfp_pkg::step_t              slots [itfp_pkg::QDepth];
  logic [itfp_pkg::QAw-1:0]     wp, rp;
  logic [itfp_pkg::QAw:0]       cnt;

  assign head     = slots[rp];
  assign is_empty = (cnt == '0);
  assign is_full  = (cnt == (itfp_pkg::QAw + 1)'(itfp_pkg::QDepth));

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      if (wr && !rd) cnt <= cnt + 1'b1;
      else if (rd && !wr) cnt <= cnt - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !is_full)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !is_empty)
    else $error("read from an empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 || is_full) |-> wp == rp)
    else $error("pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/itfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itfp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire itfp_pkg::step_t  head,
  input  wire logic             q_empty,
  output logic                  q_rd,
  input  wire logic             pop,
  output logic                  empty,
  output itfp_pkg::res_t        result
);

  logic            out_valid;
  itfp_pkg::res_t  out_reg;
  logic            second;
  logic            load;

  assign empty  = !out_valid;
  assign result = out_reg;
  assign load   = !out_valid || pop;
  assign q_rd   = load && !q_empty && (second || !head.two);

  always_ff @(posedge clk) begin
    if (load && !q_empty) out_reg <= second ? head.r1 : head.r0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      // advance to the second result or release the entry
      if (!q_empty) second <= !second && head.two;
    end
  end

  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    second |-> !q_empty && head.two)
    else $error("second result pending without its entry");

  a_second_follows_first: assert property (@(posedge clk) disable iff (rst)
    second |-> out_valid && !out_reg.last)
    else $error("first result of a pair marked last");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (second ? head.r1.last : head.r0.last))
    else $error("entry released before its last result");

endmodule

`default_nettype wire

FILE: rtl/invoice_tagged_field_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for the tagged-field data part of a payment invoice.
// Input channel: an item is taken on a clock edge with push high and full low.
//   cmd start carries the total symbol count (signature included); cmd symbol
//   carries one 5-bit data symbol. Symbols that arrive while idle are ignored.
// Result channel: while empty is low, the oldest result sits on result; it is
//   taken on an edge with pop high. last marks the final result of one input.
// Each input is parsed in the cycle it is taken and gives zero, one or two
//   results. The first result is written into the queue at the edge that takes
//   its input and then moves on into the output register when that is free.
// Throughput: one input per cycle while full is low and one result per cycle
//   while pop is high; an input that yields two results gives them out in turn.
// A four-entry queue sits between parser and output stage: when the receiver
//   stalls, full rises once it fills, and no result is lost.
// Reset (rst, synchronous) idles the parser and empties the queue and output.

module invoice_tagged_field_parser_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire itfp_pkg::in_t   item,
  output logic                 empty,
  input  wire logic            pop,
  output itfp_pkg::res_t       result
);

  logic             accept;
  logic             step_valid;
  itfp_pkg::step_t  step;
  itfp_pkg::step_t  head;
  logic             q_empty;
  logic             q_rd;

  assign accept = push && !full;

  itfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .step_valid (step_valid),
    .step       (step)
  );

  itfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (step_valid),
    .wr_data  (step),
    .rd       (q_rd),
    .head     (head),
    .is_empty (q_empty),
    .is_full  (full)
  );

  itfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire
